// File: hw/rtl/multiset_draw_without_replacement_core_assert.svh
// Assertion macros for the multiset draw core.
// Included by files that check their own control logic; no dependencies.
`ifndef MULTISET_DRAW_WITHOUT_REPLACEMENT_CORE_ASSERT_SVH
`define MULTISET_DRAW_WITHOUT_REPLACEMENT_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MDWR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MDWR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/mdwr_pkg.sv
// Shared types and constants for the multiset draw core.
// No dependencies; imported by every module of the block but the RAM.
`timescale 1ns / 1ps

package mdwr_pkg;

    localparam int MDWR_NUM_SYMBOLS = 32;

    localparam int OP_W     = 2;
    localparam int SYMBOL_W = 5;
    localparam int COUNT_W  = 8;
    localparam int TOTAL_W  = 16;
    localparam int PICK_W   = 16;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_DRAW  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY,
        ST_SCAN,
        ST_FIN
    } state_t;

    // Control of the shared accumulate and compare unit
    typedef struct packed {
        logic clear;
        logic add;
    } acc_ctrl_t;

endpackage

// File: hw/rtl/mdwr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mdwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/mdwr_accum.sv
// Shared accumulate and compare unit: running sum of counts against the pick.
// Depends on mdwr_pkg.
`timescale 1ns / 1ps

module mdwr_accum
    import mdwr_pkg::*;
#(
    parameter int SUM_W = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  acc_ctrl_t          ctrl,
    input  logic [COUNT_W-1:0] data,
    input  logic [PICK_W-1:0]  pick,
    output logic               hit
);

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0] sum_add;

    // Add the incoming count and test the pick against the new sum
    always_comb
    begin
        sum_add = sum_reg + SUM_W'(data);
        hit     = pick < PICK_W'(sum_add);
        if (ctrl.clear)
        begin
            sum_next = '0;
        end
        else if (ctrl.add)
        begin
            sum_next = sum_add;
        end
        else
        begin
            sum_next = sum_reg;
        end
    end

    // Hold the running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

// File: hw/rtl/multiset_draw_without_replacement_core.sv
// Multiset draw without replacement: a load request writes one symbol's pool
// count; a start request copies the pool into the working counts, one pool
// memory read per cycle; a draw request scans the working counts in symbol
// order through one shared accumulate-and-compare unit, one symbol per cycle,
// and ends at a hit on symbol k or after the last symbol for a miss; the
// working-count memory read port sets that pace. Each request passes through
// its work state (copy or scan, none for load) into the finish state, from
// which its result enters the output register. Each request yields one result;
// the input is not ready while a request is in work and becomes ready as its
// result enters the output register, so a new request is not accepted before
// the last one is through. A result not yet taken holds the next request in
// the finish state until the output register frees. Reset clears all pool and
// working counts at once through a valid bit per pool entry and one flag for
// the working counts, so there is no clearing pass.
// Depends on mdwr_pkg, mdwr_ram, mdwr_accum and the assertion macro header.
`timescale 1ns / 1ps

`include "multiset_draw_without_replacement_core_assert.svh"

module multiset_draw_without_replacement_core
    import mdwr_pkg::*;
#(
    parameter int NUM_SYMBOLS = MDWR_NUM_SYMBOLS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [4:0] symbol, [12:5] count, [28:13] pool_total, [44:29] pick, rest zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] operation
    input  logic [OP_W-1:0]      s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [4:0] drawn_symbol, [20:5] remaining_total, rest zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // [0] found
    output logic                 m_axis_tuser
);

    localparam int IDX_W = $clog2(NUM_SYMBOLS);
    localparam int CNT_W = $clog2(NUM_SYMBOLS + 1);
    localparam int SUM_W = $clog2(NUM_SYMBOLS * ((1 << COUNT_W) - 1) + 1);

    // Request fields
    op_t                 in_op;
    logic [SYMBOL_W-1:0] in_symbol;
    logic [COUNT_W-1:0]  in_count;
    logic [TOTAL_W-1:0]  in_total;
    logic [PICK_W-1:0]   in_pick;

    // Sequencer state
    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [PICK_W-1:0]    pick_reg, pick_next;
    logic [TOTAL_W-1:0]   remaining_reg, remaining_next;
    logic [SYMBOL_W-1:0]  res_symbol_reg, res_symbol_next;
    logic                 res_found_reg, res_found_next;
    logic [NUM_SYMBOLS-1:0] pool_valid_reg, pool_valid_next;
    logic                 pool_vq_reg, pool_vq_next;
    logic                 work_init_reg, work_init_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [SYMBOL_W-1:0]  out_symbol_reg, out_symbol_next;
    logic                 out_found_reg, out_found_next;
    logic [TOTAL_W-1:0]   out_remaining_reg, out_remaining_next;
    logic                 out_load;

    // Memory ports
    logic                 pool_we;
    logic [IDX_W-1:0]     pool_waddr;
    logic [IDX_W-1:0]     pool_raddr;
    logic                 pool_re;
    logic [COUNT_W-1:0]   pool_rdata;
    logic [COUNT_W-1:0]   pool_data;
    logic                 work_we;
    logic [IDX_W-1:0]     work_waddr;
    logic [COUNT_W-1:0]   work_wdata;
    logic [IDX_W-1:0]     work_raddr;
    logic [COUNT_W-1:0]   work_rdata;
    logic [COUNT_W-1:0]   work_data;

    // Shared unit
    acc_ctrl_t            acc_ctrl;
    logic                 acc_hit;

    // Unpack the request
    assign in_op     = op_t'(s_axis_tuser);
    assign in_symbol = s_axis_tdata[4:0];
    assign in_count  = s_axis_tdata[12:5];
    assign in_total  = s_axis_tdata[28:13];
    assign in_pick   = s_axis_tdata[44:29];

    // Entries never written read as zero
    assign pool_data = pool_vq_reg ? pool_rdata : '0;
    assign work_data = work_init_reg ? work_rdata : '0;

    mdwr_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_pool_ram (
        .clk   (clk),
        .we    (pool_we),
        .waddr (pool_waddr),
        .wdata (in_count),
        .raddr (pool_raddr),
        .rdata (pool_rdata)
    );

    mdwr_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_work_ram (
        .clk   (clk),
        .we    (work_we),
        .waddr (work_waddr),
        .wdata (work_wdata),
        .raddr (work_raddr),
        .rdata (work_rdata)
    );

    mdwr_accum #(
        .SUM_W (SUM_W)
    ) u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (acc_ctrl),
        .data  (work_data),
        .pick  (pick_reg),
        .hit   (acc_hit)
    );

    assign out_load = (state_reg == ST_FIN) && (!out_valid_reg || m_axis_tready);

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        pick_next       = pick_reg;
        remaining_next  = remaining_reg;
        res_symbol_next = res_symbol_reg;
        res_found_next  = res_found_reg;
        pool_valid_next = pool_valid_reg;
        work_init_next  = work_init_reg;
        s_axis_tready   = 1'b0;
        pool_we         = 1'b0;
        pool_waddr      = IDX_W'(in_symbol);
        pool_re         = 1'b0;
        pool_raddr      = '0;
        work_we         = 1'b0;
        work_waddr      = rd_idx_reg;
        work_wdata      = pool_data;
        work_raddr      = '0;
        acc_ctrl        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    res_symbol_next = '0;
                    res_found_next  = 1'b0;
                    cnt_next        = '0;
                    case (in_op)
                        OP_LOAD:
                        begin
                            if (32'(in_symbol) < NUM_SYMBOLS)
                            begin
                                pool_we = 1'b1;
                                pool_valid_next[IDX_W'(in_symbol)] = 1'b1;
                            end
                            state_next = ST_FIN;
                        end
                        OP_START:
                        begin
                            remaining_next = in_total;
                            work_init_next = 1'b1;
                            state_next     = ST_COPY;
                        end
                        OP_DRAW:
                        begin
                            pick_next      = in_pick;
                            acc_ctrl.clear = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end

            ST_COPY:
            begin
                // Write back the entry read last cycle
                if (rd_pend_reg)
                begin
                    work_we = 1'b1;
                end
                // Issue the next pool read
                if (cnt_reg < CNT_W'(NUM_SYMBOLS))
                begin
                    pool_re      = 1'b1;
                    pool_raddr   = cnt_reg[IDX_W-1:0];
                    rd_pend_next = 1'b1;
                    rd_idx_next  = cnt_reg[IDX_W-1:0];
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
                else if (!rd_pend_reg)
                begin
                    state_next = ST_FIN;
                end
            end

            ST_SCAN:
            begin
                // Issue the next working-count read
                if (cnt_reg < CNT_W'(NUM_SYMBOLS))
                begin
                    work_raddr   = cnt_reg[IDX_W-1:0];
                    rd_pend_next = 1'b1;
                    rd_idx_next  = cnt_reg[IDX_W-1:0];
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
                // Accumulate the entry read last cycle and test the pick
                if (rd_pend_reg)
                begin
                    acc_ctrl.add = 1'b1;
                    if (acc_hit)
                    begin
                        work_we         = 1'b1;
                        work_wdata      = work_data - COUNT_W'(1);
                        res_symbol_next = SYMBOL_W'(rd_idx_reg);
                        res_found_next  = 1'b1;
                        if (remaining_reg != '0)
                        begin
                            remaining_next = remaining_reg - TOTAL_W'(1);
                        end
                        rd_pend_next = 1'b0;
                        state_next   = ST_FIN;
                    end
                    else if (rd_idx_reg == IDX_W'(NUM_SYMBOLS - 1))
                    begin
                        state_next = ST_FIN;
                    end
                end
            end

            ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        pool_vq_next = pool_re && pool_valid_reg[pool_raddr];
    end

    // Output register: load on finish, drop when taken
    always_comb
    begin
        out_valid_next     = out_valid_reg;
        out_symbol_next    = out_symbol_reg;
        out_found_next     = out_found_reg;
        out_remaining_next = out_remaining_reg;
        if (out_load)
        begin
            out_valid_next     = 1'b1;
            out_symbol_next    = res_symbol_reg;
            out_found_next     = res_found_reg;
            out_remaining_next = remaining_reg;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            remaining_reg  <= '0;
            pool_valid_reg <= '0;
            pool_vq_reg    <= 1'b0;
            work_init_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rd_pend_reg    <= rd_pend_next;
            remaining_reg  <= remaining_next;
            pool_valid_reg <= pool_valid_next;
            pool_vq_reg    <= pool_vq_next;
            work_init_reg  <= work_init_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg        <= rd_idx_next;
        pick_reg          <= pick_next;
        res_symbol_reg    <= res_symbol_next;
        res_found_reg     <= res_found_next;
        out_symbol_reg    <= out_symbol_next;
        out_found_reg     <= out_found_next;
        out_remaining_reg <= out_remaining_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W - SYMBOL_W - TOTAL_W)'(0), out_remaining_reg,
                            out_symbol_reg};
    assign m_axis_tuser  = out_found_reg;

    // Checks on the sequencer and result path
    `MDWR_ASSERT_NEXT(a_hit_reports, clk, rst_n,
        state_reg == ST_SCAN && rd_pend_reg && acc_hit,
        state_reg == ST_FIN && res_found_reg, "draw hit not reported as found")
    `MDWR_ASSERT_NEXT(a_remaining_no_rise, clk, rst_n,
        !(s_axis_tvalid && s_axis_tready && in_op == OP_START),
        remaining_reg <= $past(remaining_reg), "remaining total rose without start")
    `MDWR_ASSERT_IMP(a_no_read_idle, clk, rst_n,
        state_reg == ST_IDLE || state_reg == ST_FIN, !rd_pend_reg,
        "memory read pending outside copy or scan")
    `MDWR_ASSERT_IMP(a_miss_zero_symbol, clk, rst_n,
        m_axis_tvalid && !m_axis_tuser, m_axis_tdata[4:0] == '0,
        "symbol reported without found")

endmodule

// File: tb/sv/mdwr_draw_checker.sv
// Checker for the multiset draw core: watches both stream channels,
// predicts the draw outcomes and compares each result field by field.
// Depends on mdwr_pkg for field widths and operation codes.
`timescale 1ns / 1ps

module mdwr_draw_checker
    import mdwr_pkg::*;
#(
    parameter int NUM_SYMBOLS = MDWR_NUM_SYMBOLS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    // [4:0] symbol, [12:5] count, [28:13] pool_total, [44:29] pick, rest zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] operation
    input  logic [OP_W-1:0]      s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [4:0] drawn_symbol, [20:5] remaining_total, rest zero
    input  logic [M_TDATA_W-1:0] m_axis_tdata,
    // [0] found
    input  logic                 m_axis_tuser,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                found;
        logic [TOTAL_W-1:0]  remaining;
    } draw_outcome_t;

    // Shadow of the block's pool, working counts and remaining total
    logic [COUNT_W-1:0] pool_mirror [NUM_SYMBOLS];
    logic [15:0]        work_counts [NUM_SYMBOLS];
    logic [TOTAL_W-1:0] remaining_items;

    draw_outcome_t draw_outcomes_q [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
        fail_count++;
    endtask

    // Apply one request to the shadow state and return the result it causes
    function automatic draw_outcome_t next_outcome(
        input logic [OP_W-1:0]     op,
        input logic [SYMBOL_W-1:0] sym,
        input logic [COUNT_W-1:0]  cnt,
        input logic [TOTAL_W-1:0]  total,
        input logic [PICK_W-1:0]   pick
    );
        draw_outcome_t res;
        int unsigned   running;
        res.symbol = '0;
        res.found  = 1'b0;
        if (op == OP_LOAD) begin
            if (int'(sym) < NUM_SYMBOLS)
                pool_mirror[sym] = cnt;
        end
        else if (op == OP_START) begin
            for (int i = 0; i < NUM_SYMBOLS; i++)
                work_counts[i] = 16'(pool_mirror[i]);
            remaining_items = total;
        end
        else if (op == OP_DRAW) begin
            running = 0;
            for (int i = 0; i < NUM_SYMBOLS; i++) begin
                running += work_counts[i];
                if (!res.found && int'(pick) < running) begin
                    work_counts[i] = work_counts[i] - 16'd1;
                    // saturate rather than wrap when the total was inconsistent
                    if (remaining_items != '0)
                        remaining_items = remaining_items - TOTAL_W'(1);
                    res.symbol = SYMBOL_W'(i);
                    res.found  = 1'b1;
                end
            end
        end
        res.remaining = remaining_items;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        draw_outcome_t want;
        if (!rst_n) begin
            for (int i = 0; i < NUM_SYMBOLS; i++) begin
                pool_mirror[i] = '0;
                work_counts[i] = '0;
            end
            remaining_items = '0;
            draw_outcomes_q.delete();
            pending <= 0;
        end
        else begin
            // check the result first: it belongs to an earlier request
            if (m_axis_tvalid && m_axis_tready) begin
                if (draw_outcomes_q.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end
                else begin
                    want = draw_outcomes_q.pop_front();
                    if (m_axis_tdata[4:0] !== want.symbol)
                        report_mismatch("drawn_symbol", int'(m_axis_tdata[4:0]),
                                        int'(want.symbol));
                    if (m_axis_tuser !== want.found)
                        report_mismatch("found", int'(m_axis_tuser), int'(want.found));
                    if (m_axis_tdata[20:5] !== want.remaining)
                        report_mismatch("remaining_total", int'(m_axis_tdata[20:5]),
                                        int'(want.remaining));
                end
            end
            // predict the accepted request
            if (s_axis_tvalid && s_axis_tready)
                draw_outcomes_q.push_back(next_outcome(s_axis_tuser, s_axis_tdata[4:0],
                    s_axis_tdata[12:5], s_axis_tdata[28:13], s_axis_tdata[44:29]));
            pending <= draw_outcomes_q.size();
        end
    end

endmodule

// File: tb/sv/testbench.sv
// Top of the multiset draw core testbench: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict.
// Depends on mdwr_pkg, the core and mdwr_draw_checker.
`timescale 1ns / 1ps

module testbench;
    import mdwr_pkg::*;

    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
    localparam int NUM_REQUESTS  = 550;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 60;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [OP_W-1:0]      s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    int fail_count;
    int pending;

    // Stimulus-side view of the pool, used only to aim the picks
    int pool_shadow [MDWR_NUM_SYMBOLS];
    int live_total;
    int requests_sent;
    int stall_cycles;

    always #5 clk = ~clk;

    multiset_draw_without_replacement_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    mdwr_draw_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Most often no gap, often a short one, now and then a long one
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offer one request after a random gap and hold it until accepted
    task automatic send_req(
        input logic [OP_W-1:0]     op,
        input logic [SYMBOL_W-1:0] sym,
        input logic [COUNT_W-1:0]  cnt,
        input logic [TOTAL_W-1:0]  total,
        input logic [PICK_W-1:0]   pick
    );
        int gap;
        gap = idle_span();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {3'b000, pick, total, cnt, sym};
        s_axis_tuser  <= op;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        requests_sent++;
    endtask

    // Unused fields carry noise on every request sent through these tasks
    task automatic send_load(input int sym, input int cnt);
        pool_shadow[sym] = cnt;
        send_req(OP_LOAD, SYMBOL_W'(sym), COUNT_W'(cnt),
                 TOTAL_W'($urandom_range(0, 65535)), PICK_W'($urandom_range(0, 65535)));
    endtask

    task automatic send_start(input int total);
        live_total = 0;
        for (int i = 0; i < MDWR_NUM_SYMBOLS; i++)
            live_total += pool_shadow[i];
        send_req(OP_START, SYMBOL_W'($urandom_range(0, 31)), COUNT_W'($urandom_range(0, 255)),
                 TOTAL_W'(total), PICK_W'($urandom_range(0, 65535)));
    endtask

    task automatic send_draw(input int pick);
        if (pick < live_total)
            live_total--;
        send_req(OP_DRAW, SYMBOL_W'($urandom_range(0, 31)), COUNT_W'($urandom_range(0, 255)),
                 TOTAL_W'($urandom_range(0, 65535)), PICK_W'(pick));
    endtask

    task automatic send_reserved();
        send_req(OP_RESERVED, SYMBOL_W'($urandom_range(0, 31)),
                 COUNT_W'($urandom_range(0, 255)), TOTAL_W'($urandom_range(0, 65535)),
                 PICK_W'($urandom_range(0, 65535)));
    endtask

    // Stimulus
    initial
    begin
        int n_loads;
        int n_draws;
        live_total    = 0;
        requests_sent = 0;
        for (int i = 0; i < MDWR_NUM_SYMBOLS; i++)
            pool_shadow[i] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // draw from an empty pool finds nothing; reserved op changes nothing
        send_draw(0);
        send_req(OP_RESERVED, 5'd31, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_load(0, 255);
        send_load(31, 255);
        send_load(7, 1);
        send_load(8, 0);
        send_start(511);
        send_draw(0);
        send_draw(65535);
        send_draw(254);
        send_draw(live_total - 1);
        send_draw(live_total);
        send_reserved();
        // start with a zero total: a found draw saturates the remaining count
        send_start(0);
        send_draw(0);
        send_draw(300);
        send_load(0, 0);
        send_load(31, 8'h55);
        send_load(16, 8'hAA);
        send_start(65535);
        send_draw(live_total - 1);
        send_draw(0);

        // Random draw sets: reshape the pool, start, then mostly in-range draws
        while (requests_sent < NUM_REQUESTS) begin
            n_loads = $urandom_range(1, 10);
            for (int k = 0; k < n_loads; k++)
                send_load($urandom_range(0, 31),
                          ($urandom_range(0, 99) < 75) ? $urandom_range(0, 6)
                                                       : $urandom_range(0, 255));
            if ($urandom_range(0, 99) < 10)
                send_reserved();
            if ($urandom_range(0, 99) < 85) begin
                live_total = 0;
                for (int i = 0; i < MDWR_NUM_SYMBOLS; i++)
                    live_total += pool_shadow[i];
                send_start(live_total);
            end
            else begin
                send_start($urandom_range(0, 65535));
            end
            n_draws = $urandom_range(3, 25);
            for (int k = 0; k < n_draws; k++) begin
                if (live_total > 0 && $urandom_range(0, 99) < 85)
                    send_draw($urandom_range(0, live_total - 1));
                else
                    send_draw($urandom_range(0, 65535));
                if ($urandom_range(0, 99) < 4)
                    send_reserved();
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then let the block settle
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Result back-pressure: random ready runs and gaps, one long hold-off
    initial
    begin
        int  seen;
        int  run_left;
        int  idle_left;
        bit  held;
        logic ready_next;
        seen      = 0;
        run_left  = 0;
        idle_left = 0;
        held      = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                seen++;
            if (!held && seen >= 40) begin
                // hold off long enough for the block to stall its input
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else begin
                if (run_left == 0 && idle_left == 0) begin
                    run_left  = $urandom_range(1, 24);
                    idle_left = idle_span();
                end
                if (run_left > 0) begin
                    ready_next = 1'b1;
                    run_left--;
                end
                else begin
                    ready_next = 1'b0;
                    idle_left--;
                end
                m_axis_tready <= ready_next;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule
